FILE: design/dfeg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DALI forward frame edge generator: shared package
// Types, widths and constants used by the front, back and top level.
// ----------------------------------------------------------------------------
package dfeg_pkg;

  // Field widths of the frame and event items.
  localparam int unsigned FrameW       = 24;
  localparam int unsigned CountW       = 5;
  localparam int unsigned TimeW        = 48;
  localparam int unsigned TicksW       = 16;

  // Longest frame that is sent; longer counts are saturated to it.
  localparam int unsigned MaxFrameBits = 24;

  // Width of the left-aligned data shift register.
  localparam int unsigned AlignW = (MaxFrameBits > FrameW) ? MaxFrameBits : FrameW;
  localparam int unsigned ShiftW = $clog2(AlignW + 1);

  // Configuration register indexes and reset values.
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgHalfBitTicks = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgFullBitTicks = 1'b1;
  localparam logic [TicksW-1:0]  HalfBitReset    = 16'd417;
  localparam logic [TicksW-1:0]  FullBitReset    = 16'd833;

  // One forward frame as accepted at the input.
  typedef struct packed {
    logic [FrameW-1:0] frame_bits;
    logic [CountW-1:0] bit_count;
    logic [TimeW-1:0]  start_time;
  } frame_t;

  // One timed bus-level edge event.
  typedef struct packed {
    logic             line_level;
    logic [TimeW-1:0] event_time;
    logic             last_event;
  } edge_t;

  // Classified frame handed from the front to the back.
  typedef struct packed {
    logic [AlignW-1:0] data;
    logic [CountW-1:0] len;
    logic [TimeW-1:0]  start_time;
  } cmd_t;

  // Timing configuration.
  typedef struct packed {
    logic [TicksW-1:0] half_bit_ticks;
    logic [TicksW-1:0] full_bit_ticks;
  } cfg_t;

endpackage

FILE: design/dfeg_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DALI edge generator: front end
// Accepts frames, saturates the bit count, left-aligns the data so that the
// first bit to send sits at the top, and queues the result for the back end.
// ----------------------------------------------------------------------------
module dfeg_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  input  dfeg_pkg::frame_t frame_i,
  output logic            full,
  output logic            cmd_valid_o,
  output dfeg_pkg::cmd_t  cmd_o,
  input  logic            cmd_pop_i
);
  import dfeg_pkg::*;

  localparam int unsigned Depth = 2;

  logic [CountW-1:0] len_sat;
  logic [ShiftW-1:0] shamt;
  logic [AlignW-1:0] data_ext;
  cmd_t              cmd_new;
  cmd_t              queue_q [Depth];
  logic              wr_ptr_q, wr_ptr_d;
  logic              rd_ptr_q, rd_ptr_d;
  logic [1:0]        count_q, count_d;
  logic              do_push;

  // Classify: saturate the count and align the first bit to the MSB.
  always_comb begin
    if (frame_i.bit_count > CountW'(MaxFrameBits)) begin
      len_sat = CountW'(MaxFrameBits);
    end else begin
      len_sat = frame_i.bit_count;
    end
    shamt    = ShiftW'(AlignW) - ShiftW'(len_sat);
    data_ext = AlignW'(frame_i.frame_bits);
    cmd_new.data       = data_ext << shamt;
    cmd_new.len        = len_sat;
    cmd_new.start_time = frame_i.start_time;
  end

  // Two-entry queue between the front and the back.
  assign full        = (count_q == 2'(Depth));
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = queue_q[rd_ptr_q];
  assign do_push     = push && !full;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (cmd_pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    case ({do_push, cmd_pop_i})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage holds payload only.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      queue_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

FILE: design/dfeg_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DALI edge generator: back end
// Walks one classified frame bit by bit and produces one timed edge event per
// cycle into an output register, stalling while it is full and not popped.
// ----------------------------------------------------------------------------
module dfeg_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  dfeg_pkg::cfg_t cfg_i,
  input  logic           cmd_valid_i,
  input  dfeg_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  output logic           empty,
  output dfeg_pkg::edge_t edge_o,
  input  logic           pop
);
  import dfeg_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_BIT,
    S_MID,
    S_STOP
  } state_e;

  state_e            state_q, state_d;
  logic [TimeW-1:0]  time_q, time_d;
  logic [AlignW-1:0] data_q, data_d;
  logic [CountW-1:0] rem_q, rem_d;
  logic              level_q, level_d;
  logic              out_valid_q;
  edge_t             out_q;

  logic              advance;
  logic              fire;
  edge_t             ev;
  logic              use_full;
  logic [TicksW-1:0] step;
  logic [TimeW-1:0]  sum;
  logic              bit_cur;
  logic              last_bit;

  assign advance  = !out_valid_q || pop;
  assign bit_cur  = data_q[AlignW-1];
  assign last_bit = (rem_q == CountW'(1));
  // A data bit that differs from the line level takes one full-bit step.
  assign use_full = (state_q == S_BIT) && (bit_cur != level_q);
  assign step     = use_full ? cfg_i.full_bit_ticks : cfg_i.half_bit_ticks;
  assign sum      = time_q + TimeW'(step);

  // Event sequencer: start bit, data bits, then an optional stop edge.
  always_comb begin
    state_d  = state_q;
    time_d   = time_q;
    data_d   = data_q;
    rem_d    = rem_q;
    level_d  = level_q;
    fire     = 1'b0;
    ev       = '0;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          fire          = 1'b1;
          ev.line_level = 1'b0;
          ev.event_time = cmd_i.start_time;
          ev.last_event = 1'b0;
          time_d        = cmd_i.start_time;
          data_d        = cmd_i.data;
          rem_d         = cmd_i.len;
          level_d       = 1'b0;
          state_d       = S_START;
        end
      end
      S_START: begin
        fire          = 1'b1;
        time_d        = sum;
        level_d       = 1'b1;
        ev.line_level = 1'b1;
        ev.event_time = sum;
        ev.last_event = (rem_q == '0);
        state_d       = (rem_q == '0) ? S_IDLE : S_BIT;
      end
      S_BIT: begin
        fire   = 1'b1;
        time_d = sum;
        if (bit_cur != level_q) begin
          // Differing bit: a single toggle one full bit later.
          level_d       = ~level_q;
          ev.line_level = ~level_q;
          ev.event_time = sum;
          ev.last_event = last_bit && !level_q;
          data_d        = data_q << 1;
          rem_d         = rem_q - CountW'(1);
          if (last_bit) begin
            state_d = level_q ? S_STOP : S_IDLE;
          end
        end else begin
          // Equal bit: first of two half-bit toggles.
          ev.line_level = ~level_q;
          ev.event_time = sum;
          ev.last_event = 1'b0;
          state_d       = S_MID;
        end
      end
      S_MID: begin
        fire          = 1'b1;
        time_d        = sum;
        ev.line_level = level_q;
        ev.event_time = sum;
        ev.last_event = last_bit && level_q;
        data_d        = data_q << 1;
        rem_d         = rem_q - CountW'(1);
        if (last_bit) begin
          state_d = level_q ? S_IDLE : S_STOP;
        end else begin
          state_d = S_BIT;
        end
      end
      S_STOP: begin
        fire          = 1'b1;
        time_d        = sum;
        level_d       = 1'b1;
        ev.line_level = 1'b1;
        ev.event_time = sum;
        ev.last_event = 1'b1;
        state_d       = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign cmd_pop_o = advance && (state_q == S_IDLE) && cmd_valid_i;
  assign empty     = !out_valid_q;
  assign edge_o    = out_q;

  // Sequencer state and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      time_q      <= '0;
      data_q      <= '0;
      rem_q       <= '0;
      level_q     <= 1'b1;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else if (advance) begin
      state_q     <= state_d;
      time_q      <= time_d;
      data_q      <= data_d;
      rem_q       <= rem_d;
      level_q     <= level_d;
      out_valid_q <= fire;
      if (fire) begin
        out_q <= ev;
      end
    end
  end

endmodule

FILE: design/dali_forward_frame_edge_generator_core.sv
`timescale 1ns / 1ps
// The first edge of a frame passes through the front-end queue and then the
// back-end output register. Throughput: one edge event per cycle from the
// back-end sequencer unless its output register is full and not popped; a
// two-entry queue lets the next frames be accepted meanwhile.
// Reset (asynchronous, active low) empties the queue and output register and
// restores the half-bit and full-bit periods to 417 and 833 ticks.
// ----------------------------------------------------------------------------
// DALI forward frame edge generator: top level
// Turns forward frames into timed biphase bus edges, with a configuration
// port for the half-bit and full-bit periods.
// ----------------------------------------------------------------------------
module dali_forward_frame_edge_generator_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [dfeg_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [dfeg_pkg::TicksW-1:0]    cfg_wdata_i,
  input  logic                           push,
  input  dfeg_pkg::frame_t               in_item_i,
  output logic                           full,
  output logic                           empty,
  input  logic                           pop,
  output dfeg_pkg::edge_t                out_item_o
);
  import dfeg_pkg::*;

  cfg_t cfg_q;
  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_bit_ticks <= HalfBitReset;
      cfg_q.full_bit_ticks <= FullBitReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgHalfBitTicks: cfg_q.half_bit_ticks <= cfg_wdata_i;
        CfgFullBitTicks: cfg_q.full_bit_ticks <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Front end: classification and queue.
  dfeg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .frame_i     (in_item_i),
    .full        (full),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // Back end: edge sequencer and output register.
  dfeg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .empty       (empty),
    .edge_o      (out_item_o),
    .pop         (pop)
  );

  // The last edge of every frame leaves the bus high.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.last_event) |-> out_item_o.line_level)
    else $error("final edge of a frame is not high");

  // The back end never takes a frame from an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid)
    else $error("frame taken from an empty queue");

  // A full queue accepts nothing, so its state is held without a pop.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full && !cmd_pop) |=> full)
    else $error("queue left full state without a transfer to the back end");

endmodule
